>>> rtl/core/qcf_pkg.sv
`default_nettype none

package qcf_pkg;

  // Coordinate width, fixed by the point and corner fields.
  localparam int COORD_BITS = 12;
  localparam int DEFAULT_MAX_POINTS = 4096;

  // The squared distance needs 2*COORD_BITS+1 bits, so its root has COORD_BITS+1 bits.
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int RAD_W = 2 * ROOT_W;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  // One stored point on its way through the distance pipeline.
  typedef struct packed {
    logic                  valid;
    corner_t               corner;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } walk_tag_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV_START,
    ST_DIVIDE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/qcf_point_store.sv
`default_nettype none

module qcf_point_store import qcf_pkg::*; #(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS,
  localparam int ADDR_W = $clog2(MAX_POINTS)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [COORD_BITS-1:0] wr_x,
  input  logic [COORD_BITS-1:0] wr_y,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output logic [COORD_BITS-1:0] rd_x,
  output logic [COORD_BITS-1:0] rd_y
);

  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_data;

  // Writes happen only while loading and reads only while walking, so the
  // two ports never touch the same entry in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_x = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_y = rd_data[COORD_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/core/qcf_divider.sv
`default_nettype none

module qcf_divider import qcf_pkg::*; #(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS,
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int SUM_W = COORD_BITS + CNT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_W-1:0]      num_x,
  input  logic [SUM_W-1:0]      num_y,
  input  logic [CNT_W-1:0]      den,
  output logic                  done,
  output logic [COORD_BITS-1:0] quo_x,
  output logic [COORD_BITS-1:0] quo_y
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  acc_x;
  logic [SUM_W-1:0]  acc_y;
  logic [CNT_W-1:0]  rem_x;
  logic [CNT_W-1:0]  rem_y;
  logic [CNT_W:0]    rem_sh_x;
  logic [CNT_W:0]    rem_sh_y;
  logic [CNT_W:0]    den_ext;
  logic              ge_x;
  logic              ge_y;

  // Restoring division, one quotient bit per cycle for both lanes. The
  // quotient bits shift into the dividend register as its bits shift out.
  always_comb begin
    den_ext  = {1'b0, den};
    rem_sh_x = {rem_x, acc_x[SUM_W-1]};
    rem_sh_y = {rem_y, acc_y[SUM_W-1]};
    ge_x     = rem_sh_x >= den_ext;
    ge_y     = rem_sh_y >= den_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_x <= num_x;
      acc_y <= num_y;
      rem_x <= '0;
      rem_y <= '0;
    end else if (running) begin
      acc_x <= {acc_x[SUM_W-2:0], ge_x};
      acc_y <= {acc_y[SUM_W-2:0], ge_y};
      rem_x <= ge_x ? CNT_W'(rem_sh_x - den_ext) : rem_sh_x[CNT_W-1:0];
      rem_y <= ge_y ? CNT_W'(rem_sh_y - den_ext) : rem_sh_y[CNT_W-1:0];
    end
  end

  // An average of coordinates always fits a coordinate.
  assign quo_x = acc_x[COORD_BITS-1:0];
  assign quo_y = acc_y[COORD_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/core/qcf_isqrt.sv
`default_nettype none

module qcf_isqrt import qcf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  walk_tag_t         in_tag,
  input  logic [RAD_W-1:0]  in_rad,
  output walk_tag_t         out_tag,
  output logic [ROOT_W-1:0] out_root,
  output logic              busy
);

  localparam int REM_W = ROOT_W + 3;

  walk_tag_t          tag_q  [ROOT_W];
  logic [RAD_W-1:0]   rad_q  [ROOT_W];
  logic [REM_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0]  root_q [ROOT_W];

  walk_tag_t          tag_i  [ROOT_W];
  logic [RAD_W-1:0]   rad_i  [ROOT_W];
  logic [REM_W-1:0]   rem_i  [ROOT_W];
  logic [ROOT_W-1:0]  root_i [ROOT_W];

  logic [REM_W-1:0]   rem_sh [ROOT_W];
  logic [REM_W-1:0]   trial  [ROOT_W];
  logic               ge     [ROOT_W];

  // One root bit per stage: bring down two radicand bits and try (root<<2)|1.
  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign tag_i[g]  = in_tag;
      assign rad_i[g]  = in_rad;
      assign rem_i[g]  = '0;
      assign root_i[g] = '0;
    end else begin : g_next
      assign tag_i[g]  = tag_q[g-1];
      assign rad_i[g]  = rad_q[g-1];
      assign rem_i[g]  = rem_q[g-1];
      assign root_i[g] = root_q[g-1];
    end

    assign rem_sh[g] = {rem_i[g][REM_W-3:0], rad_i[g][RAD_W-1 -: 2]};
    assign trial[g]  = REM_W'({root_i[g], 2'b01});
    assign ge[g]     = rem_sh[g] >= trial[g];

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[g] <= '0;
      end else begin
        tag_q[g] <= tag_i[g];
      end
      rad_q[g]  <= {rad_i[g][RAD_W-3:0], 2'b00};
      rem_q[g]  <= ge[g] ? rem_sh[g] - trial[g] : rem_sh[g];
      root_q[g] <= {root_i[g][ROOT_W-2:0], ge[g]};
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int i = 0; i < ROOT_W; i++) begin
      busy = busy | tag_q[i].valid;
    end
  end

  assign out_tag  = tag_q[ROOT_W-1];
  assign out_root = root_q[ROOT_W-1];

endmodule

`default_nettype wire

>>> rtl/core/qcf_measure.sv
`default_nettype none

module qcf_measure import qcf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic [COORD_BITS-1:0] cx,
  input  logic [COORD_BITS-1:0] cy,
  output walk_tag_t             res_tag,
  output logic [ROOT_W-1:0]     res_dist,
  output logic                  busy
);

  logic                    lt_x;
  logic                    gt_x;
  logic                    lt_y;
  logic                    gt_y;
  logic                    in_quad;
  corner_t                 corner;
  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;

  walk_tag_t               tag_a;
  logic [COORD_BITS-1:0]   dx_a;
  logic [COORD_BITS-1:0]   dy_a;
  walk_tag_t               tag_b;
  logic [2*COORD_BITS-1:0] dx2_b;
  logic [2*COORD_BITS-1:0] dy2_b;
  walk_tag_t               tag_c;
  logic [2*COORD_BITS:0]   sq_c;
  logic                    root_busy;

  // A point on either axis through the centroid belongs to no quadrant.
  always_comb begin
    lt_x    = in_x < cx;
    gt_x    = in_x > cx;
    lt_y    = in_y < cy;
    gt_y    = in_y > cy;
    in_quad = 1'b1;
    corner  = CORNER_TL;
    if (lt_x && lt_y) begin
      corner = CORNER_TL;
    end else if (gt_x && lt_y) begin
      corner = CORNER_TR;
    end else if (gt_x && gt_y) begin
      corner = CORNER_BR;
    end else if (lt_x && gt_y) begin
      corner = CORNER_BL;
    end else begin
      in_quad = 1'b0;
    end
    dx = gt_x ? in_x - cx : cx - in_x;
    dy = gt_y ? in_y - cy : cy - in_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
      tag_b <= '0;
      tag_c <= '0;
    end else begin
      tag_a <= '{valid: in_valid && in_quad, corner: corner, x: in_x, y: in_y};
      tag_b <= tag_a;
      tag_c <= tag_b;
    end
    dx_a  <= dx;
    dy_a  <= dy;
    dx2_b <= dx_a * dx_a;
    dy2_b <= dy_a * dy_a;
    sq_c  <= {1'b0, dx2_b} + {1'b0, dy2_b};
  end

  qcf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_tag   (tag_c),
    .in_rad   ({1'b0, sq_c}),
    .out_tag  (res_tag),
    .out_root (res_dist),
    .busy     (root_busy)
  );

  assign busy = tag_a.valid | tag_b.valid | tag_c.valid | root_busy;

endmodule

`default_nettype wire

>>> rtl/core/quadrant_corner_finder.sv
`default_nettype none

// Finds the four outer corners of one contour. Points arrive one per cycle
// when point_stall is low and are written to an on-chip point memory while
// their coordinates are summed; the last point closes the contour. The
// centroid is then formed by a bit-serial divider, the point memory is read
// back one point per cycle into a pipeline that classifies each point by
// quadrant, squares, and takes an exact integer square root one bit per
// stage, and finally four corner transactions are issued in the order
// top-left, top-right, bottom-right, bottom-left. No new point is accepted
// from the last point until the final corner has been loaded into the output
// register. Points beyond MAX_POINTS are dropped, though their last flag
// still closes the contour.
module quadrant_corner_finder import qcf_pkg::*; #(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  last_point,
  output logic                  corner_valid,
  input  logic                  corner_stall,
  output logic [1:0]            corner_index,
  output logic [COORD_BITS-1:0] corner_x,
  output logic [COORD_BITS-1:0] corner_y,
  output logic                  corner_found,
  output logic                  empty_contour,
  output logic                  last_corner
);

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_BITS + CNT_W;

  state_t                state;
  state_t                state_next;

  logic [SUM_W-1:0]      sum_x;
  logic [SUM_W-1:0]      sum_y;
  logic [CNT_W-1:0]      point_count;
  logic [CNT_W-1:0]      walk_idx;
  logic                  rd_valid;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  corner_t               emit_idx;

  logic [ROOT_W-1:0]     best_dist [4];
  logic [COORD_BITS-1:0] best_x    [4];
  logic [COORD_BITS-1:0] best_y    [4];

  logic                  point_accept;
  logic                  store_room;
  logic                  store_we;
  logic                  div_start;
  logic                  div_done;
  logic [COORD_BITS-1:0] quo_x;
  logic [COORD_BITS-1:0] quo_y;
  logic                  rd_en;
  logic [COORD_BITS-1:0] rd_x;
  logic [COORD_BITS-1:0] rd_y;
  walk_tag_t             meas_tag;
  logic [ROOT_W-1:0]     meas_dist;
  logic                  meas_busy;
  logic                  emit_load;
  logic                  emit_found;

  assign point_stall  = (state != ST_LOAD);
  assign point_accept = point_valid && !point_stall;
  assign store_room   = point_count < CNT_W'(MAX_POINTS);
  assign store_we     = point_accept && store_room;
  assign emit_found   = best_dist[emit_idx] != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    rd_en      = 1'b0;
    emit_load  = 1'b0;
    case (state)
      ST_LOAD: begin
        if (point_accept && last_point) begin
          // This branch is never taken: a zero count always leaves store room.
          if (point_count == '0 && !store_room) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_DIV_START;
          end
        end
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_idx != point_count) begin
          rd_en = 1'b1;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !meas_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!corner_valid || !corner_stall) begin
          emit_load = 1'b1;
          if (emit_idx == CORNER_BL) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x         <= '0;
      sum_y         <= '0;
      point_count   <= '0;
      walk_idx      <= '0;
      rd_valid      <= 1'b0;
      emit_idx      <= CORNER_TL;
      corner_valid  <= 1'b0;
      corner_index  <= '0;
      corner_x      <= '0;
      corner_y      <= '0;
      corner_found  <= 1'b0;
      empty_contour <= 1'b0;
      last_corner   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        best_dist[i] <= '0;
        best_x[i]    <= '0;
        best_y[i]    <= '0;
      end
    end else begin
      if (store_we) begin
        sum_x       <= sum_x + SUM_W'(point_x);
        sum_y       <= sum_y + SUM_W'(point_y);
        point_count <= point_count + 1'b1;
      end

      if (state == ST_DIVIDE && div_done) begin
        walk_idx <= '0;
      end else if (rd_en) begin
        walk_idx <= walk_idx + 1'b1;
      end
      rd_valid <= rd_en;

      // First strictly larger distance wins within its quadrant.
      if (meas_tag.valid && meas_dist > best_dist[meas_tag.corner]) begin
        best_dist[meas_tag.corner] <= meas_dist;
        best_x[meas_tag.corner]    <= meas_tag.x;
        best_y[meas_tag.corner]    <= meas_tag.y;
      end

      if (state == ST_DRAIN || state == ST_LOAD) begin
        emit_idx <= CORNER_TL;
      end

      if (emit_load) begin
        corner_valid  <= 1'b1;
        corner_index  <= emit_idx;
        corner_x      <= emit_found ? best_x[emit_idx] : '0;
        corner_y      <= emit_found ? best_y[emit_idx] : '0;
        corner_found  <= emit_found;
        empty_contour <= (point_count == '0);
        last_corner   <= (emit_idx == CORNER_BL);
        emit_idx      <= corner_t'(emit_idx + 2'd1);
        if (emit_idx == CORNER_BL) begin
          sum_x       <= '0;
          sum_y       <= '0;
          point_count <= '0;
          for (int i = 0; i < 4; i++) begin
            best_dist[i] <= '0;
            best_x[i]    <= '0;
            best_y[i]    <= '0;
          end
        end
      end else if (corner_valid && !corner_stall) begin
        corner_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && div_done) begin
      cx <= quo_x;
      cy <= quo_y;
    end
  end

  qcf_point_store #(.MAX_POINTS(MAX_POINTS)) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (point_count[ADDR_W-1:0]),
    .wr_x    (point_x),
    .wr_y    (point_y),
    .rd_en   (rd_en),
    .rd_addr (walk_idx[ADDR_W-1:0]),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  qcf_divider #(.MAX_POINTS(MAX_POINTS)) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_x (sum_x),
    .num_y (sum_y),
    .den   (point_count),
    .done  (div_done),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  qcf_measure u_measure (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .in_x     (rd_x),
    .in_y     (rd_y),
    .cx       (cx),
    .cy       (cy),
    .res_tag  (meas_tag),
    .res_dist (meas_dist),
    .busy     (meas_busy)
  );

endmodule

`default_nettype wire

>>> rtl/core/qcf_checker.sv
`default_nettype none

module qcf_checker import qcf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  point_stall,
  input logic                  corner_valid,
  input logic                  corner_stall,
  input logic [1:0]            corner_index,
  input logic [COORD_BITS-1:0] corner_x,
  input logic [COORD_BITS-1:0] corner_y,
  input logic                  corner_found,
  input logic                  empty_contour,
  input logic                  last_corner
);

  a_corner_hold: assert property (@(posedge clk) disable iff (rst)
    corner_valid && corner_stall |=> corner_valid && $stable(corner_index)
      && $stable(corner_x) && $stable(corner_y))
    else $error("corner transaction changed while stalled");

  a_last_marks_bl: assert property (@(posedge clk) disable iff (rst)
    corner_valid |-> last_corner == (corner_index == CORNER_BL))
    else $error("last_corner does not match the bottom-left corner");

  a_missing_is_zero: assert property (@(posedge clk) disable iff (rst)
    corner_valid && !corner_found |-> corner_x == '0 && corner_y == '0)
    else $error("corner without a point carries nonzero coordinates");

  a_empty_not_found: assert property (@(posedge clk) disable iff (rst)
    corner_valid && empty_contour |-> !corner_found)
    else $error("empty contour reports a found corner");

  a_busy_after_first: assert property (@(posedge clk) disable iff (rst)
    corner_valid && !corner_stall && corner_index == CORNER_TL |=> point_stall)
    else $error("points accepted before all corners were issued");

endmodule

bind quadrant_corner_finder qcf_checker u_qcf_checker (
  .clk           (clk),
  .rst           (rst),
  .point_stall   (point_stall),
  .corner_valid  (corner_valid),
  .corner_stall  (corner_stall),
  .corner_index  (corner_index),
  .corner_x      (corner_x),
  .corner_y      (corner_y),
  .corner_found  (corner_found),
  .empty_contour (empty_contour),
  .last_corner   (last_corner)
);

`default_nettype wire
